FILE: hdl/radio_mode_switch_with_owner_set_core_assert.svh
// Assertion macros used by the checker file of the radio mode switch.
`ifndef RADIO_MODE_SWITCH_WITH_OWNER_SET_CORE_ASSERT_SVH
`define RADIO_MODE_SWITCH_WITH_OWNER_SET_CORE_ASSERT_SVH

// Clocked check, off while reset is high.
`define RMSOS_ASSERT_RST(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check, also active during reset.
`define RMSOS_ASSERT_CLK(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/rmsos_pkg.sv
// Package of the radio mode switch: widths, codes, types and the command decoder.
`timescale 1ns / 1ps

package rmsos_pkg;

   localparam int OWNER_SLOTS = 8;
   localparam int SLOT_IDX_W  = (OWNER_SLOTS > 1) ? $clog2(OWNER_SLOTS) : 1;
   localparam int COUNT_W     = $clog2(OWNER_SLOTS + 1);

   localparam int CMD_W       = 3;
   localparam int ID_W        = 31;
   localparam int MODE_W      = 2;
   localparam int OUT_COUNT_W = 4;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 16;

   localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ON    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_HALF  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_OWNER = 2'd3;

   localparam logic [CMD_W-1:0] CMD_ON      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_HALF    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DISABLE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_OWNER   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_INIT    = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CHECK   = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                  wr_en;
      logic [SLOT_IDX_W-1:0] wr_idx;
      logic [SLOT_IDX_W-1:0] rd_idx;
   } set_ctrl_type;

   typedef struct packed {
      logic               rej;
      logic [MODE_W-1:0]  mode;
      logic               persist;
      logic               access;
      logic               wr_en;
      logic               wr_zero;
      logic [COUNT_W-1:0] count;
   } outcome_type;

   function automatic outcome_type decide(
      input logic [MODE_W-1:0]  mode,
      input logic [CMD_W-1:0]   cmd,
      input logic [MODE_W-1:0]  rmode,
      input logic               hit,
      input logic [COUNT_W-1:0] count
   );
      outcome_type o;
      logic        enter;
      logic        seed;
      logic        add;
      o         = '0;
      o.mode    = mode;
      enter     = 1'b0;
      seed      = 1'b0;
      add       = 1'b0;
      if (cmd == CMD_CHECK) begin
         o.access = (mode != MODE_OWNER) || hit;
      end else begin
         case (mode)
            MODE_OFF: begin
               case (cmd)
                  CMD_ON: begin
                     enter = 1'b1; o.mode = MODE_ON; o.persist = 1'b1;
                  end
                  CMD_HALF: begin
                     enter = 1'b1; o.mode = MODE_HALF; o.persist = 1'b1;
                  end
                  CMD_OWNER: begin
                     enter = 1'b1; seed = 1'b1; o.mode = MODE_OWNER; o.persist = 1'b1;
                  end
                  CMD_INIT: begin
                     if (rmode != MODE_OFF) begin
                        enter = 1'b1; o.mode = rmode; o.persist = 1'b1;
                     end
                  end
                  default: o.rej = 1'b1;
               endcase
            end
            MODE_ON: begin
               case (cmd)
                  CMD_ON: ;
                  CMD_HALF: begin
                     enter = 1'b1; o.mode = MODE_HALF; o.persist = 1'b1;
                  end
                  CMD_DISABLE: begin
                     enter = 1'b1; o.mode = MODE_OFF;
                  end
                  default: o.rej = 1'b1;
               endcase
            end
            MODE_HALF: begin
               case (cmd)
                  CMD_ON: begin
                     enter = 1'b1; o.mode = MODE_ON; o.persist = 1'b1;
                  end
                  CMD_DISABLE: begin
                     enter = 1'b1; o.mode = MODE_OFF;
                  end
                  default: o.rej = 1'b1;
               endcase
            end
            default: begin
               case (cmd)
                  CMD_ON: begin
                     enter = 1'b1; o.mode = MODE_ON; o.persist = 1'b1;
                  end
                  CMD_HALF: begin
                     enter = 1'b1; o.mode = MODE_HALF; o.persist = 1'b1;
                  end
                  CMD_DISABLE: begin
                     enter = 1'b1; o.mode = MODE_OFF;
                  end
                  CMD_OWNER: begin
                     if (count >= COUNT_W'(OWNER_SLOTS)) o.rej = 1'b1;
                     else add = !hit;
                  end
                  default: o.rej = 1'b1;
               endcase
            end
         endcase
      end
      o.wr_en   = seed | add;
      o.wr_zero = seed;
      if (seed)       o.count = COUNT_W'(1);
      else if (enter) o.count = '0;
      else if (add)   o.count = count + COUNT_W'(1);
      else            o.count = count;
      return o;
   endfunction

endpackage

FILE: hdl/rmsos_owner_set.sv
// Owner id slots with the shared id comparator used by the scan.
`timescale 1ns / 1ps

module rmsos_owner_set (
   input  logic                      clock,
   input  rmsos_pkg::set_ctrl_type   ctrl,
   input  logic [rmsos_pkg::ID_W-1:0] id,
   output logic                      match
);

   logic [rmsos_pkg::ID_W-1:0] slot_ff [rmsos_pkg::OWNER_SLOTS];

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         slot_ff[ctrl.wr_idx] <= id;
      end
   end

   assign match = (slot_ff[ctrl.rd_idx] == id);

endmodule

FILE: hdl/radio_mode_switch_with_owner_set_core.sv
// Top level of the radio mode switch: command sequencer, mode and count state, result register.
//
//   channel | dir | fields (low bit first)
//   req_    | in  | command[2:0] owner_id[33:3] restore_mode[35:34]
//   rsp_    | out | status[0] mode_now[2:1] persist_write[3] owner_access[4] owner_count[8:5]
//
// An item passes the idle and done states, with the scan state between them when the owner
// set is searched (check or owner add in owner-only mode); the scan compares at most
// owner_count slots; one id comparator visits one slot per cycle and stops at the first hit.
// Reset empties the owner set and selects off. req_tready is high while idle;
// a held result stalls the sequencer in its final step only.
`timescale 1ns / 1ps

module radio_mode_switch_with_owner_set_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rmsos_pkg::REQ_DATA_W-1:0]  req_tdata,  // command, owner_id, restore_mode
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rmsos_pkg::RSP_DATA_W-1:0]  rsp_tdata   // status, mode_now, persist_write,
                                                         // owner_access, owner_count
);

   rmsos_pkg::state_type                     state_ff, state_in;
   logic [rmsos_pkg::CMD_W-1:0]              cmd_ff;
   logic [rmsos_pkg::ID_W-1:0]               id_ff;
   logic [rmsos_pkg::MODE_W-1:0]             rmode_ff;
   logic                                     hit_ff;
   logic [rmsos_pkg::SLOT_IDX_W-1:0]         idx_ff;
   logic [rmsos_pkg::MODE_W-1:0]             mode_ff;
   logic [rmsos_pkg::COUNT_W-1:0]            count_ff;
   logic                                     rsp_valid_ff;
   logic [rmsos_pkg::RSP_DATA_W-1:0]         rsp_data_ff, rsp_data_in;

   logic [rmsos_pkg::CMD_W-1:0]              req_cmd;
   logic [rmsos_pkg::ID_W-1:0]               req_id;
   logic [rmsos_pkg::MODE_W-1:0]             req_rmode;
   logic                                     req_fire;
   logic                                     need_scan;
   logic                                     match;
   logic                                     scan_last;
   logic                                     out_free;
   logic                                     commit;
   rmsos_pkg::outcome_type                   outcome;
   rmsos_pkg::set_ctrl_type                  set_ctrl;

   assign req_cmd   = req_tdata[2:0];
   assign req_id    = req_tdata[33:3];
   assign req_rmode = req_tdata[35:34];
   assign req_fire  = req_tvalid & req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   assign need_scan = (mode_ff == rmsos_pkg::MODE_OWNER) && (count_ff != '0) &&
                      ((req_cmd == rmsos_pkg::CMD_CHECK) ||
                       ((req_cmd == rmsos_pkg::CMD_OWNER) &&
                        (count_ff < rmsos_pkg::COUNT_W'(rmsos_pkg::OWNER_SLOTS))));

   assign scan_last = (rmsos_pkg::COUNT_W'(idx_ff) + rmsos_pkg::COUNT_W'(1)) == count_ff;

   assign outcome = rmsos_pkg::decide(mode_ff, cmd_ff, rmode_ff, hit_ff, count_ff);

   rmsos_owner_set u_owner_set (
      .clock (clock),
      .ctrl  (set_ctrl),
      .id    (id_ff),
      .match (match)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rmsos_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = need_scan ? rmsos_pkg::ST_SCAN : rmsos_pkg::ST_DONE;
            end
         end
         rmsos_pkg::ST_SCAN: begin
            if (match || scan_last) state_in = rmsos_pkg::ST_DONE;
         end
         rmsos_pkg::ST_DONE: begin
            if (out_free) state_in = rmsos_pkg::ST_IDLE;
         end
         default: state_in = rmsos_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready      = 1'b0;
      commit          = 1'b0;
      set_ctrl.rd_idx = idx_ff;
      set_ctrl.wr_idx = outcome.wr_zero ? '0 : count_ff[rmsos_pkg::SLOT_IDX_W-1:0];
      set_ctrl.wr_en  = 1'b0;
      case (state_ff)
         rmsos_pkg::ST_IDLE: req_tready = 1'b1;
         rmsos_pkg::ST_DONE: begin
            commit         = out_free;
            set_ctrl.wr_en = out_free && outcome.wr_en;
         end
         default: ;
      endcase
   end

   assign rsp_data_in = {{(rmsos_pkg::RSP_DATA_W - 5 - rmsos_pkg::OUT_COUNT_W){1'b0}},
                         rmsos_pkg::OUT_COUNT_W'(outcome.count),
                         outcome.access, outcome.persist, outcome.mode, outcome.rej};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rmsos_pkg::ST_IDLE;
         mode_ff      <= rmsos_pkg::MODE_OFF;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            mode_ff      <= outcome.mode;
            count_ff     <= outcome.count;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff   <= req_cmd;
         id_ff    <= req_id;
         rmode_ff <= req_rmode;
         hit_ff   <= 1'b0;
         idx_ff   <= '0;
      end else if (state_ff == rmsos_pkg::ST_SCAN) begin
         hit_ff <= match;
         idx_ff <= idx_ff + rmsos_pkg::SLOT_IDX_W'(1);
      end
      if (commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: hdl/rmsos_checker.sv
// Port-level checks of the radio mode switch and their binding to the top level.
`timescale 1ns / 1ps
`include "radio_mode_switch_with_owner_set_core_assert.svh"

module rmsos_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [rmsos_pkg::REQ_DATA_W-1:0]  req_tdata,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [rmsos_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   logic out_mode_not_owner;
   logic req_seen;

   assign out_mode_not_owner = rsp_tdata[2:1] != rmsos_pkg::MODE_OWNER;
   assign req_seen           = req_tvalid & req_tready & (req_tdata != '1);

   `RMSOS_ASSERT_CLK(a_reset_empty, clock, reset |=> !rsp_tvalid, "result valid after reset")
   `RMSOS_ASSERT_RST(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "result dropped while stalled")
   `RMSOS_ASSERT_RST(a_set_empty, clock, reset, rsp_tvalid && out_mode_not_owner |-> rsp_tdata[8:5] == '0, "owner set not empty outside owner-only")
   `RMSOS_ASSERT_RST(a_persist_ok, clock, reset, rsp_tvalid && rsp_tdata[3] |-> !rsp_tdata[0], "persist on a rejected item")
   `RMSOS_ASSERT_RST(a_one_busy, clock, reset, req_seen |=> !req_tready, "second item taken while busy")

endmodule

bind radio_mode_switch_with_owner_set_core rmsos_checker u_rmsos_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
